### src/ssb_pkg.sv
// ----------------------------------------------------------------------------
// Scaled sprite blitter package
// Shared widths, command, status and register codes, and request and result payload types.
// ----------------------------------------------------------------------------
package ssb_pkg;

  localparam int SCREEN_WIDTH_DEF  = 1024;
  localparam int SCREEN_HEIGHT_DEF = 768;
  localparam int TEX_DEPTH_DEF     = 4096;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_BEGIN = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;

  localparam logic [1:0] ST_NONE   = 2'd0;
  localparam logic [1:0] ST_WRITE  = 2'd1;
  localparam logic [1:0] ST_DONE   = 2'd2;
  localparam logic [1:0] ST_REJECT = 2'd3;

  localparam logic [2:0] REG_DEST_X = 3'd0;
  localparam logic [2:0] REG_DEST_Y = 3'd1;
  localparam logic [2:0] REG_DEST_W = 3'd2;
  localparam logic [2:0] REG_DEST_H = 3'd3;
  localparam logic [2:0] REG_TEX_W  = 3'd4;
  localparam logic [2:0] REG_TEX_H  = 3'd5;
  localparam logic [2:0] REG_GLYPH  = 3'd6;
  localparam logic [2:0] REG_KEY    = 3'd7;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [11:0] texel_index;
    logic [31:0] texel_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] screen_addr;
    logic [31:0] pixel_color;
  } res_t;

endpackage

### src/ssb_if.sv
// ----------------------------------------------------------------------------
// Blitter channel interfaces
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface ssb_req_if;
  import ssb_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ssb_res_if;
  import ssb_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/ssb_queue.sv
// ----------------------------------------------------------------------------
// Blitter request queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module ssb_queue import ssb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output req_t out_data
);
  req_t entry [2];
  logic rd_ptr;
  logic wr_ptr;
  logic [1:0] count;
  logic push;
  logic pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = entry[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= in_data;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assert property (@(posedge clk) disable iff (rst) (count == 2'd2) |-> !in_ready)
    else $error("queue full but ready");
  assert property (@(posedge clk) disable iff (rst) (push && !pop) |=> (count != 2'd0))
    else $error("queue lost an entry");
  assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count overflow");
endmodule

### src/ssb_engine.sv
// ----------------------------------------------------------------------------
// Blitter engine
// Executes loads, begin setup (with a serial divider) and pixel steps; other requests get an empty result.
// ----------------------------------------------------------------------------
module ssb_engine import ssb_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int TEX_DEPTH     = TEX_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  req_t        in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        out_data,
  input  logic [12:0] dest_x,
  input  logic [12:0] dest_y,
  input  logic [11:0] dest_w,
  input  logic [11:0] dest_h,
  input  logic [6:0]  tex_width,
  input  logic [6:0]  tex_height,
  input  logic        glyph_mode,
  input  logic [31:0] key_or_ink
);
  localparam int AW = (TEX_DEPTH > 1) ? $clog2(TEX_DEPTH) : 1;
  localparam logic [13:0] SW = 14'(SCREEN_WIDTH);
  localparam logic [13:0] SH = 14'(SCREEN_HEIGHT);
  localparam logic signed [21:0] SW_W = 22'(SCREEN_WIDTH);
  localparam logic signed [21:0] SH_W = 22'(SCREEN_HEIGHT);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIVS  = 4'd1;  // size derivation divide
  localparam logic [3:0] S_DIVU  = 4'd2;  // step_u divide
  localparam logic [3:0] S_DIVV  = 4'd3;  // step_v divide
  localparam logic [3:0] S_PREU  = 4'd4;
  localparam logic [3:0] S_PREV  = 4'd5;
  localparam logic [3:0] S_CHECK = 4'd6;
  localparam logic [3:0] S_PIX   = 4'd7;  // texel read issued
  localparam logic [3:0] S_PIX2  = 4'd8;  // compare and emit
  localparam logic [3:0] S_ROW   = 4'd9;  // row change guard check

  logic [3:0] state;
  logic [31:0] mem [TEX_DEPTH];
  logic [31:0] rd_data;
  logic [31:0] texel0;
  logic [AW-1:0] rd_addr;

  logic signed [13:0] cur_col, cur_row, row_start_col, end_col, end_row;
  logic [23:0] tex_u, tex_v, row_start_u, step_u, step_v;
  logic drawing;
  // A derived size can reach 4095 * 127, so sizes carry 20 bits.
  logic [19:0] w, h;
  logic [6:0] tx, ty;
  logic signed [13:0] x, y;
  logic signed [21:0] mx, my;
  logic reject;
  logic empty_rect;

  // serial divider: quotient of num / den
  logic [23:0] num;
  logic [23:0] quo;
  logic [23:0] div_q;
  logic [19:0] rem;
  logic [19:0] den;
  logic [4:0]  dcnt;
  logic        derive_w;
  logic [20:0] rem_sh;
  logic [24:0] prod;
  logic [13:0] area;
  logic        guard;
  logic        pix_ok;
  logic [19:0] addr_q;
  logic        res_full;
  res_t        res_q;

  assign out_valid = res_full;
  assign out_data  = res_q;
  assign in_ready  = (state == S_IDLE) && (!res_full || out_ready);

  assign tx = (tex_width == 7'd0) ? 7'd1 : tex_width;
  assign ty = (tex_height == 7'd0) ? 7'd1 : tex_height;
  assign area = 14'(tx) * 14'(ty);
  assign guard = ({8'd0, tex_u[23:16]} * {8'd0, tex_v[23:16]}) < 16'(area);
  assign rem_sh = {rem, num[23]};
  // A zero divisor gives a zero step.
  assign div_q = (den == 20'd0) ? 24'd0 : quo;

  assign mx = $signed({2'b00, w}) + $signed({{8{x[13]}}, x});
  assign my = $signed({2'b00, h}) + $signed({{8{y[13]}}, y});
  assign reject = mx[21] || my[21] || x > $signed(SW) || y > $signed(SH);
  assign empty_rect = w == 20'd0 || h == 20'd0 || cur_col >= end_col ||
                      cur_row >= end_row || !guard;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready && in_data.cmd == CMD_LOAD &&
        {20'd0, in_data.texel_index} < 32'(TEX_DEPTH)) begin
      mem[AW'(in_data.texel_index)] <= in_data.texel_value;
    end
    rd_data <= mem[rd_addr];
    texel0  <= mem[0];
  end

  logic emit;
  res_t emit_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      drawing <= 1'b0;
      res_full <= 1'b0;
      cur_col <= '0; cur_row <= '0; row_start_col <= '0;
      end_col <= '0; end_row <= '0;
      tex_u <= '0; tex_v <= '0; row_start_u <= '0;
      step_u <= '0; step_v <= '0;
    end else begin
      if (out_valid && out_ready) res_full <= 1'b0;
      if (emit) begin
        res_full <= 1'b1;
        res_q <= emit_res;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            if (in_data.cmd == CMD_BEGIN) begin
              drawing <= 1'b0;
              x <= {dest_x[12], dest_x};
              y <= {dest_y[12], dest_y};
              w <= 20'(dest_w);
              h <= 20'(dest_h);
              if (dest_w == 12'd0 && dest_h == 12'd0) begin
                w <= 20'(tx);
                h <= 20'(ty);
                state <= S_DIVU;
                num <= {1'b0, tx, 16'd0};
                den <= 20'(tx);
              end else if (dest_w == 12'd0 || dest_h == 12'd0) begin
                derive_w <= (dest_w == 12'd0);
                num <= (dest_w == 12'd0) ? 24'(dest_h * 19'(tx)) : 24'(dest_w * 19'(ty));
                den <= (dest_w == 12'd0) ? 20'(ty) : 20'(tx);
                state <= S_DIVS;
              end else begin
                num <= {1'b0, tx, 16'd0};
                den <= 20'(dest_w);
                state <= S_DIVU;
              end
              rem <= '0;
              dcnt <= '0;
            end else if (in_data.cmd == CMD_STEP && drawing) begin
              if (!(cur_col < end_col && guard)) begin
                tex_v <= tex_v + step_v;
                cur_row <= cur_row + 14'sd1;
                state <= S_ROW;
              end else begin
                rd_addr <= AW'(32'(tex_v[23:16]) * 32'(tx) + 32'(tex_u[23:16]));
                state <= S_PIX;
              end
            end
          end
        end
        S_DIVS, S_DIVU, S_DIVV: begin
          // restoring divide, one quotient bit per cycle
          if (dcnt != 5'd24 && den != 20'd0) begin
            num <= {num[22:0], 1'b0};
            if (rem_sh >= {1'b0, den}) begin
              rem <= 20'(rem_sh - {1'b0, den});
              quo <= {quo[22:0], 1'b1};
            end else begin
              rem <= rem_sh[19:0];
              quo <= {quo[22:0], 1'b0};
            end
            dcnt <= dcnt + 5'd1;
          end else begin
            rem <= '0;
            dcnt <= '0;
            if (state == S_DIVS) begin
              if (derive_w) begin
                w <= div_q[19:0];
                den <= div_q[19:0];
              end else begin
                h <= div_q[19:0];
                den <= w;
              end
              num <= {1'b0, tx, 16'd0};
              state <= S_DIVU;
            end else if (state == S_DIVU) begin
              step_u <= div_q;
              num <= {1'b0, ty, 16'd0};
              den <= h;
              state <= S_DIVV;
            end else begin
              step_v <= div_q;
              state <= S_PREU;
            end
          end
        end
        S_PREU: begin
          end_col <= (mx < SW_W) ? mx[13:0] : SW;
          end_row <= (my < SH_W) ? my[13:0] : SH;
          tex_u <= x[13] ? 24'(25'(-x) * 25'(step_u)) : 24'd0;
          state <= S_PREV;
        end
        S_PREV: begin
          tex_v <= y[13] ? 24'(25'(-y) * 25'(step_v)) : 24'd0;
          row_start_col <= x[13] ? 14'sd0 : x;
          cur_col <= x[13] ? 14'sd0 : x;
          cur_row <= y[13] ? 14'sd0 : y;
          row_start_u <= tex_u;
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (!reject && !empty_rect) drawing <= 1'b1;
          state <= S_IDLE;
        end
        S_ROW: begin
          if (!(cur_row < end_row && guard)) begin
            drawing <= 1'b0;
            state <= S_IDLE;
          end else begin
            cur_col <= row_start_col;
            tex_u <= row_start_u;
            rd_addr <= AW'(32'(tex_v[23:16]) * 32'(tx) + 32'(row_start_u[23:16]));
            state <= S_PIX;
          end
        end
        S_PIX: state <= S_PIX2;
        S_PIX2: begin
          tex_u <= tex_u + step_u;
          cur_col <= cur_col + 14'sd1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // read index beyond the store answers zero
  logic [31:0] texel;
  assign pix_ok = cur_col >= 0 && cur_col < $signed(SW) && cur_row >= 0 &&
                  cur_row < $signed(SH) && tex_u[23:16] < 8'(tx) && tex_v[23:16] < 8'(ty);
  assign addr_q = 20'(32'(cur_row) * 32'(SCREEN_WIDTH) + 32'(cur_col));
  assign prod = 25'(32'(tex_v[23:16]) * 32'(tx) + 32'(tex_u[23:16]));
  assign texel = (32'(prod) < 32'(TEX_DEPTH)) ? rd_data : 32'd0;

  always_comb begin
    emit = 1'b0;
    emit_res = '0;
    unique case (state)
      S_IDLE: emit = in_valid && in_ready &&
                     !(in_data.cmd == CMD_BEGIN || (in_data.cmd == CMD_STEP && drawing));
      S_CHECK: begin
        emit = 1'b1;
        if (reject)
          emit_res.status = ST_REJECT;
        else if (empty_rect)
          emit_res.status = ST_DONE;
      end
      S_ROW: if (!(cur_row < end_row && guard)) begin
        emit = 1'b1;
        emit_res.status = ST_DONE;
      end
      S_PIX2: begin
        emit = 1'b1;
        if (pix_ok) begin
          if (glyph_mode ? (texel != texel0) : (texel != key_or_ink)) begin
            emit_res.status = ST_WRITE;
            emit_res.screen_addr = addr_q;
            emit_res.pixel_color = glyph_mode ? key_or_ink : texel;
          end
        end
      end
      default: emit = 1'b0;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) (state == S_PIX) |=> (state == S_PIX2))
    else $error("pixel read sequence broken");
  assert property (@(posedge clk) disable iff (rst) (state != S_IDLE) |-> !in_ready)
    else $error("accepting while busy");
  assert property (@(posedge clk) disable iff (rst) emit |-> (!res_full || out_ready))
    else $error("result overwritten");
endmodule

### src/scaled_sprite_blitter_unit.sv
// ----------------------------------------------------------------------------
// Scaled sprite blitter
// Nearest-neighbor scaled texture copy with color key or glyph ink fill.
// ----------------------------------------------------------------------------
//  channel   dir   payload
//  req       in    cmd, texel_index, texel_value
//  res       out   status, screen_addr, pixel_color
//  cfg       in    cfg_we, cfg_index, cfg_data
//
// A load is taken in the idle state; a pixel step goes through the texel store
// read and compare states, a row change through the row check first. A begin
// request runs three serial divides (two when no size is derived; a zero
// divisor ends at once), then the setup states PREU, PREV and CHECK.
// Reset is synchronous; the texture store is not cleared. Requests pass a
// two-entry queue so the host is not stalled by the engine until it is full,
// and results sit in an output register so a stalled sink only holds the engine.
module scaled_sprite_blitter_unit import ssb_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int TEX_DEPTH     = TEX_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ssb_req_if.sink     req,
  ssb_res_if.source   res,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  logic [12:0] dest_x, dest_y;
  logic [11:0] dest_w, dest_h;
  logic [6:0]  tex_width, tex_height;
  logic        glyph_mode;
  logic [31:0] key_or_ink;

  // Configuration registers, to be written only while idle; the block itself does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      dest_x <= '0; dest_y <= '0; dest_w <= '0; dest_h <= '0;
      tex_width <= 7'd64; tex_height <= 7'd64;
      glyph_mode <= 1'b0; key_or_ink <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEST_X: dest_x <= cfg_data[12:0];
        REG_DEST_Y: dest_y <= cfg_data[12:0];
        REG_DEST_W: dest_w <= cfg_data[11:0];
        REG_DEST_H: dest_h <= cfg_data[11:0];
        REG_TEX_W:  tex_width <= cfg_data[6:0];
        REG_TEX_H:  tex_height <= cfg_data[6:0];
        REG_GLYPH:  glyph_mode <= cfg_data[0];
        REG_KEY:    key_or_ink <= cfg_data;
        default:    key_or_ink <= key_or_ink;
      endcase
    end
  end

  logic q_valid, q_ready;
  req_t q_data;

  // Front: requests are queued as they arrive.
  ssb_queue u_queue (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
    .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
  );

  // Back: the engine executes one request at a time.
  ssb_engine #(
    .SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT), .TEX_DEPTH(TEX_DEPTH)
  ) u_engine (
    .clk(clk), .rst(rst),
    .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
    .out_valid(res.valid), .out_ready(res.ready), .out_data(res.data),
    .dest_x(dest_x), .dest_y(dest_y), .dest_w(dest_w), .dest_h(dest_h),
    .tex_width(tex_width), .tex_height(tex_height),
    .glyph_mode(glyph_mode), .key_or_ink(key_or_ink)
  );
endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scaled sprite blitter testbench
// Drives texel loads, draw starts and pixel steps through the request channel
// and checks every result against a cycle-free model of the blit kept here.
// ----------------------------------------------------------------------------
module tb;
  import ssb_pkg::*;

  localparam int SW = SCREEN_WIDTH_DEF;
  localparam int SH = SCREEN_HEIGHT_DEF;
  localparam int TD = TEX_DEPTH_DEF;
  localparam int RANDOM_REQUESTS = 470;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 120;
  // Textures never cover more texels than this, so loading this many
  // entries up front means no draw reads an unwritten texel.
  localparam int TEX_REACH = 128;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  ssb_req_if req ();
  ssb_res_if res ();

  scaled_sprite_blitter_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req.sink),
    .res       (res.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Register shadow of the block's configuration.
  logic signed [12:0] org_x, org_y;
  logic [11:0]        size_w, size_h;
  logic [6:0]         tex_w, tex_h;
  logic               glyph;
  logic [31:0]        key_ink;

  // Blit state as the block should hold it.
  logic [31:0] texels [TD];
  int          col, row, row_col, last_col, last_row;
  logic [23:0] u, v, row_u, du, dv;
  bit          busy;

  res_t        pending_results [$];
  int          errors = 0;
  int          sent = 0;
  int          cycles = 0;
  int          gap_pct = 33;
  int          stall_pct = 76;

  function automatic int eff_w();
    return (tex_w == 0) ? 1 : int'(tex_w);
  endfunction

  function automatic int eff_h();
    return (tex_h == 0) ? 1 : int'(tex_h);
  endfunction

  function automatic logic [31:0] texel_at(int idx);
    return (idx < TD) ? texels[idx] : 32'd0;
  endfunction

  // The block keeps drawing only while the integer texture
  // coordinates, multiplied, stay below the texel count.
  function automatic bit guard_ok();
    return int'(u[23:16]) * int'(v[23:16]) < eff_w() * eff_h();
  endfunction

  // Works out the result of one request and advances the blit state.
  function automatic res_t blit_predict(req_t r);
    res_t o;
    int   w, h, tx, ty, x, y, mx, my, iu, iv;
    logic [31:0] tex;
    bit   visit;
    o = '0;
    tx = eff_w();
    ty = eff_h();
    case (r.cmd)
      CMD_LOAD: texels[r.texel_index] = r.texel_value;
      CMD_BEGIN: begin
        busy = 0;
        w = int'(size_w);
        h = int'(size_h);
        // A zero size is filled in from the texture's aspect ratio.
        if (w == 0 && h == 0) begin
          w = tx;
          h = ty;
        end else if (w == 0) begin
          w = h * tx / ty;
        end else if (h == 0) begin
          h = w * ty / tx;
        end
        du = (w != 0) ? 24'((tx << 16) / w) : 24'd0;
        dv = (h != 0) ? 24'((ty << 16) / h) : 24'd0;
        x = int'(org_x);
        y = int'(org_y);
        mx = w + x;
        my = h + y;
        if (mx < 0 || my < 0 || x > SW || y > SH) begin
          o.status = ST_REJECT;
        end else begin
          last_col = (mx < SW) ? mx : SW;
          last_row = (my < SH) ? my : SH;
          u = (x < 0) ? 24'(longint'(-x) * longint'(du)) : 24'd0;
          v = (y < 0) ? 24'(longint'(-y) * longint'(dv)) : 24'd0;
          row_col = (x < 0) ? 0 : x;
          col = row_col;
          row = (y < 0) ? 0 : y;
          row_u = u;
          if (w == 0 || h == 0 || col >= last_col || row >= last_row || !guard_ok())
            o.status = ST_DONE;
          else
            busy = 1;
        end
      end
      CMD_STEP: begin
        if (busy) begin
          visit = 1;
          if (!(col < last_col && guard_ok())) begin
            v = v + dv;
            row++;
            if (!(row < last_row && guard_ok())) begin
              busy = 0;
              visit = 0;
              o.status = ST_DONE;
            end else begin
              col = row_col;
              u = row_u;
            end
          end
          if (visit) begin
            iu = int'(u[23:16]);
            iv = int'(v[23:16]);
            if (col >= 0 && col < SW && row >= 0 && row < SH && iu < tx && iv < ty) begin
              tex = texel_at(iv * tx + iu);
              if (glyph ? (tex != texel_at(0)) : (tex != key_ink)) begin
                o.status = ST_WRITE;
                o.screen_addr = 20'(row * SW + col);
                o.pixel_color = glyph ? key_ink : tex;
              end
            end
            u = u + du;
            col++;
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // Result side: random back-pressure, compare against the oldest prediction.
  always @(posedge clk) begin
    res_t want;
    res.ready <= ($urandom_range(0, 99) >= stall_pct);
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
    if (!rst && res.valid && res.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: %p", res.data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (res.data.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, res.data.status);
          errors++;
        end
        if (res.data.screen_addr !== want.screen_addr) begin
          $error("screen_addr: expected %0h, actual %0h", want.screen_addr,
                 res.data.screen_addr);
          errors++;
        end
        if (res.data.pixel_color !== want.pixel_color) begin
          $error("pixel_color: expected %0h, actual %0h", want.pixel_color,
                 res.data.pixel_color);
          errors++;
        end
      end
    end
  end

  // Sends one request; valid stays up into the next request unless a gap
  // is drawn, so it is never dropped and raised in the same step.
  task automatic send_req(input req_t r, input bit typed, input logic [1:0] typed_status);
    res_t p;
    if ($urandom_range(0, 99) < gap_pct) begin
      req.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
    end
    req.valid <= 1'b1;
    req.data  <= r;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    p = blit_predict(r);
    if (typed) begin
      p = '0;
      p.status = typed_status;
    end
    pending_results.push_back(p);
    sent++;
  endtask

  task automatic send_cmd(input logic [1:0] c, input logic [11:0] idx, input logic [31:0] val);
    req_t r;
    r.cmd = c;
    r.texel_index = idx;
    r.texel_value = val;
    send_req(r, 1'b0, ST_NONE);
  endtask

  // Registers change only once every result is back and the engine has had
  // time to finish any request that leaves nothing behind.
  task automatic settle();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_DEST_X: org_x   = data[12:0];
      REG_DEST_Y: org_y   = data[12:0];
      REG_DEST_W: size_w  = data[11:0];
      REG_DEST_H: size_h  = data[11:0];
      REG_TEX_W:  tex_w   = data[6:0];
      REG_TEX_H:  tex_h   = data[6:0];
      REG_GLYPH:  glyph   = data[0];
      REG_KEY:    key_ink = data;
      default: ;
    endcase
  endtask

  function automatic logic [6:0] pick_tex_dim();
    case ($urandom_range(0, 29))
      0:       return 7'($urandom_range(0, 127));
      1, 2, 3: return 7'd64;
      default: return 7'($urandom_range(0, 8));
    endcase
  endfunction

  function automatic int pick_origin(int far_edge);
    case ($urandom_range(0, 9))
      0, 1:    return far_edge - 8 + int'($urandom_range(0, 14));
      2:       return int'($urandom_range(0, 8191)) - 4096;
      default: return int'($urandom_range(0, 20)) - 8;
    endcase
  endfunction

  function automatic logic [31:0] pick_color();
    case ($urandom_range(0, 3))
      0:       return key_ink;
      1:       return texels[0];
      default: return $urandom;
    endcase
  endfunction

  // New random configuration. Big destinations are placed against an edge
  // so that clipping leaves only a few pixels to visit.
  task automatic random_setup();
    int w, h, x, y, twd, th_max;
    settle();
    twd = int'(pick_tex_dim());
    th_max = TEX_REACH / ((twd == 0) ? 1 : twd);
    if (th_max > 127) th_max = 127;
    write_reg(REG_TEX_W, 32'(twd));
    write_reg(REG_TEX_H, ($urandom_range(0, 3) == 0) ? 32'(th_max)
                         : 32'($urandom_range(0, (th_max > 8) ? 8 : th_max)));
    if ($urandom_range(0, 15) == 0) begin
      w = int'($urandom_range(3000, 4095));
      h = ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(3000, 4095));
      x = ($urandom_range(0, 1) == 0) ? SW - int'($urandom_range(0, 6))
                                      : int'($urandom_range(0, 6)) - w;
      if (x < -4096) x = -4096;
      y = ($urandom_range(0, 3) == 0) ? -4096 : SH - int'($urandom_range(0, 6));
    end else begin
      w = int'($urandom_range(0, 10));
      h = int'($urandom_range(0, 10));
      x = pick_origin(SW);
      y = pick_origin(SH);
    end
    write_reg(REG_DEST_X, 32'(x) & 32'h1fff);
    write_reg(REG_DEST_Y, 32'(y) & 32'h1fff);
    write_reg(REG_DEST_W, 32'(w));
    write_reg(REG_DEST_H, 32'(h));
    write_reg(REG_GLYPH, 32'($urandom_range(0, 1)));
    write_reg(REG_KEY, ($urandom_range(0, 2) == 0) ? $urandom : texels[$urandom_range(0, 15)]);
  endtask

  typedef struct {
    bit          is_cfg;
    logic [2:0]  reg_idx;
    logic [31:0] reg_data;
    req_t        rq;
    int          reps;
    bit          typed;
    logic [1:0]  typed_status;
  } dir_row_t;

  dir_row_t dir_rows [$];

  function automatic void add_cfg(logic [2:0] idx, logic [31:0] data);
    dir_rows.push_back('{1'b1, idx, data, '0, 1, 1'b0, ST_NONE});
  endfunction

  function automatic void add_req(logic [1:0] c, logic [11:0] idx, logic [31:0] val,
                                  int reps, bit typed, logic [1:0] st);
    req_t r;
    r.cmd = c;
    r.texel_index = idx;
    r.texel_value = val;
    dir_rows.push_back('{1'b0, 3'd0, 32'd0, r, reps, typed, st});
  endfunction

  // Idle mix by progress through the random part: receiver idles first,
  // then the sender, then neither.
  function automatic void set_idle_mix(int done);
    if (done < RANDOM_REQUESTS / 3) begin
      gap_pct = 33; stall_pct = 76;
    end else if (done < 2 * RANDOM_REQUESTS / 3) begin
      gap_pct = 76; stall_pct = 33;
    end else begin
      gap_pct = 0; stall_pct = 0;
    end
  endfunction

  initial begin
    int base, steps;
    req.valid <= 1'b0;
    req.data  <= '0;
    res.ready = 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_DEST_X;
    cfg_data  <= '0;
    org_x = '0; org_y = '0; size_w = '0; size_h = '0;
    tex_w = 7'd64; tex_h = 7'd64; glyph = 1'b0; key_ink = '0;
    col = 0; row = 0; row_col = 0; last_col = 0; last_row = 0;
    u = '0; v = '0; row_u = '0; du = '0; dv = '0; busy = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // A step while idle and an unknown command both answer with no write.
    add_req(CMD_STEP, 12'd0, 32'd0, 1, 1'b1, ST_NONE);
    add_req(2'd3, 12'hfff, 32'hffffffff, 1, 1'b1, ST_NONE);

    // Fill every texel that a draw can reach before anything is drawn.
    for (int i = 0; i < TEX_REACH; i++) add_req(CMD_LOAD, 12'(i), $urandom, 1, 1'b1, ST_NONE);
    add_req(CMD_LOAD, 12'd0, 32'hffffffff, 1, 1'b1, ST_NONE);
    add_req(CMD_LOAD, 12'd4095, 32'd0, 1, 1'b1, ST_NONE);
    add_req(CMD_LOAD, 12'd1, 32'd0, 1, 1'b1, ST_NONE);
    // 2x2 texture blown up to 4 wide, height derived; texel 1 matches the key.
    add_cfg(REG_TEX_W, 32'd2);
    add_cfg(REG_TEX_H, 32'd2);
    add_cfg(REG_DEST_W, 32'd4);
    add_req(CMD_BEGIN, 12'd0, 32'd0, 1, 1'b0, ST_NONE);
    add_req(CMD_STEP, 12'd0, 32'd0, 18, 1'b0, ST_NONE);
    // Same draw as a glyph with full-scale ink.
    add_cfg(REG_GLYPH, 32'd1);
    add_cfg(REG_KEY, 32'hffffffff);
    add_req(CMD_BEGIN, 12'd0, 32'd0, 1, 1'b0, ST_NONE);
    add_req(CMD_STEP, 12'd0, 32'd0, 18, 1'b0, ST_NONE);
    // Left of the screen entirely, then right of it.
    add_cfg(REG_DEST_X, 32'h1000);
    add_cfg(REG_DEST_W, 32'd100);
    add_req(CMD_BEGIN, 12'd0, 32'd0, 1, 1'b1, ST_REJECT);
    add_cfg(REG_DEST_X, 32'h0fff);
    add_req(CMD_BEGIN, 12'd0, 32'd0, 1, 1'b1, ST_REJECT);
    // A derived height of zero leaves nothing to draw.
    add_cfg(REG_DEST_X, 32'd0);
    add_cfg(REG_TEX_W, 32'd64);
    add_cfg(REG_TEX_H, 32'd1);
    add_cfg(REG_DEST_W, 32'd1);
    add_req(CMD_BEGIN, 12'd0, 32'd0, 1, 1'b1, ST_DONE);
    // Zero texture size counts as one texel; the top edge far above.
    add_cfg(REG_DEST_W, 32'd0);
    add_cfg(REG_TEX_W, 32'd0);
    add_cfg(REG_TEX_H, 32'd0);
    add_req(CMD_BEGIN, 12'd0, 32'd0, 1, 1'b0, ST_NONE);
    add_req(CMD_STEP, 12'd0, 32'd0, 3, 1'b0, ST_NONE);
    add_cfg(REG_DEST_Y, 32'h1000);
    add_req(CMD_BEGIN, 12'd0, 32'd0, 1, 1'b1, ST_REJECT);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        settle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_data);
      end else begin
        repeat (dir_rows[i].reps)
          send_req(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].typed_status);
      end
    end

    // Random draws: configure, load a few texels, begin, then step the
    // draw to its end with the odd stray request mixed in.
    base = sent;
    while (sent - base < RANDOM_REQUESTS) begin
      set_idle_mix(sent - base);
      random_setup();
      repeat ($urandom_range(0, 5))
        send_cmd(CMD_LOAD, 12'($urandom_range(0, eff_w() * eff_h() - 1) % TD), pick_color());
      send_cmd(CMD_BEGIN, 12'($urandom), $urandom);
      steps = 0;
      while (busy && steps < 200 && sent - base < RANDOM_REQUESTS) begin
        set_idle_mix(sent - base);
        case ($urandom_range(0, 49))
          0: send_cmd(CMD_LOAD, 12'($urandom_range(0, eff_w() * eff_h() - 1) % TD),
                      pick_color());
          1: send_cmd(2'd3, 12'($urandom), $urandom);
          2: send_cmd(CMD_BEGIN, 12'($urandom), $urandom);
          default: send_cmd(CMD_STEP, 12'($urandom), $urandom);
        endcase
        steps++;
      end
      repeat ($urandom_range(0, 2)) send_cmd(CMD_STEP, 12'($urandom), $urandom);
    end

    settle();
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      errors++;
    end
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
